// ----- rtl/nmac_pkg.sv -----
// ----------------------------------------------------------------------------
// nmac_pkg
// Shared widths, defaults and controller/datapath interface types for the
// neuron multiply-accumulate with activation.
// ----------------------------------------------------------------------------
package nmac_pkg;

  localparam int DATA_W             = 16;
  localparam int ACC_W              = 40;
  localparam int ACT_W              = 14;
  localparam int FRAC_BITS_DEF      = 12;
  localparam int ACT_TABLE_SIZE_DEF = 256;

  typedef struct packed {
    logic ld_in;
    logic mul;
    logic ld_direct;
    logic acc;
    logic add_bias;
    logic round;
    logic map;
    logic rd_hi;
    logic cap_lo;
    logic mix;
    logic out_load;
  } nmac_cmd_t;

  typedef struct packed {
    logic mode;
    logic last;
    logic out_busy;
  } nmac_sts_t;

endpackage

// ----- rtl/nmac_act_rom.sv -----
// ----------------------------------------------------------------------------
// nmac_act_rom
// Activation sample table, -tanh(x/2) over [-8,8], registered read.
// ----------------------------------------------------------------------------
module nmac_act_rom #(
  parameter int FRAC_BITS      = nmac_pkg::FRAC_BITS_DEF,
  parameter int ACT_TABLE_SIZE = nmac_pkg::ACT_TABLE_SIZE_DEF
) (
  input  logic                                     clk,
  input  logic [$clog2(ACT_TABLE_SIZE + 1)-1:0]    addr,
  output logic signed [FRAC_BITS + 1:0]            data
);
  import nmac_pkg::*;

  localparam int IDX_W = $clog2(ACT_TABLE_SIZE + 1);
  localparam int T_W   = FRAC_BITS + 2;

  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-|x| from a series at |x|/16 squared four times, then (1-E)/(1+E)
  function automatic logic [63:0] act_sample(input int i, input int s, input int f);
    logic [63:0] ad;
    logic [63:0] w;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] m;
    int          d;
    d    = 2 * i - s;
    ad   = 64'((d < 0) ? -d : d);
    w    = udiv(ad << 30, 64'(2 * s));
    term = 64'd1 << 30;
    e    = term;
    for (int k = 1; k <= 24; k++) begin
      term = udiv((term * w) >> 30, 64'(k));
      if (k[0]) begin
        e = e - term;
      end else begin
        e = e + term;
      end
    end
    for (int k = 0; k < 4; k++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    num = ((64'd1 << 30) - e) << f;
    den = (64'd1 << 30) + e;
    m   = udiv(num * 2 + den, den * 2);
    return (d > 0) ? -m : m;
  endfunction

  logic signed [T_W-1:0] tab [2**IDX_W];

  for (genvar i = 0; i < 2**IDX_W; i++) begin : g_tab
    if (i <= ACT_TABLE_SIZE) begin : g_on
      localparam logic [63:0] SAMPLE = act_sample(i, ACT_TABLE_SIZE, FRAC_BITS);
      assign tab[i] = SAMPLE[T_W-1:0];
    end else begin : g_off
      assign tab[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    data <= tab[addr];
  end

endmodule

// ----- rtl/nmac_dp.sv -----
// ----------------------------------------------------------------------------
// nmac_dp
// Datapath: term multiplier, saturating accumulator, bias and rounding,
// table lookup with interpolation, output register.
// ----------------------------------------------------------------------------
module nmac_dp #(
  parameter int FRAC_BITS      = nmac_pkg::FRAC_BITS_DEF,
  parameter int ACT_TABLE_SIZE = nmac_pkg::ACT_TABLE_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic signed [nmac_pkg::DATA_W-1:0]  cfg_wdata,
  input  logic                                mode,
  input  logic signed [nmac_pkg::DATA_W-1:0]  value,
  input  logic signed [nmac_pkg::DATA_W-1:0]  weight,
  input  logic                                last,
  input  nmac_pkg::nmac_cmd_t                 cmd,
  output nmac_pkg::nmac_sts_t                 sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [nmac_pkg::ACT_W-1:0]   activation,
  output logic                                saturated
);
  import nmac_pkg::*;

  localparam int IDX_W = $clog2(ACT_TABLE_SIZE + 1);
  localparam int U_W   = FRAC_BITS + 4;
  localparam int X_W   = ACC_W + 1 - FRAC_BITS;
  localparam int T_W   = FRAC_BITS + 2;
  localparam int S_W   = U_W + IDX_W;
  localparam int MIX_W = T_W + U_W + 2;
  localparam int P_W   = 2 * DATA_W;

  localparam logic signed [ACC_W:0]   RND_HALF  = (ACC_W + 1)'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [X_W:0]     HALF_SPAN = (X_W + 1)'(1) <<< (FRAC_BITS + 3);
  localparam logic [S_W-1:0]          SCALE     = S_W'(ACT_TABLE_SIZE);
  localparam logic [IDX_W-1:0]        LAST_IDX  = IDX_W'(ACT_TABLE_SIZE);
  localparam logic signed [MIX_W-1:0] MIX_HALF  = MIX_W'(1) <<< (U_W - 1);
  localparam logic signed [MIX_W-1:0] ACT_MAX   = MIX_W'((2**(ACT_W - 1)) - 1);
  localparam logic signed [MIX_W-1:0] ACT_MIN   = -MIX_W'(2**(ACT_W - 1));

  logic signed [DATA_W-1:0] bias;
  logic                     in_mode;
  logic signed [DATA_W-1:0] in_value;
  logic signed [DATA_W-1:0] in_weight;
  logic                     in_last;
  logic signed [P_W-1:0]    prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     clip_seen;
  logic signed [ACC_W-1:0]  total;
  logic                     res_clip;
  logic signed [X_W-1:0]    x;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         idx_hi;
  logic [U_W-1:0]           rem;
  logic signed [T_W-1:0]    t_lo;
  logic signed [MIX_W-1:0]  mix;
  logic signed [T_W-1:0]    rom_data;
  logic [IDX_W-1:0]         rom_addr;

  logic signed [ACC_W:0]    acc_sum;
  logic                     acc_ovf;
  logic signed [ACC_W-1:0]  acc_sat;
  logic signed [ACC_W:0]    bias_sum;
  logic                     bias_ovf;
  logic signed [ACC_W-1:0]  bias_sat;
  logic signed [ACC_W:0]    rnd_sum;
  logic signed [X_W:0]      u;
  logic                     u_low;
  logic                     u_high;
  logic [S_W-1:0]           scaled;
  logic [IDX_W-1:0]         idx_next;
  logic [IDX_W-1:0]         idx_hi_next;
  logic [U_W-1:0]           rem_next;
  logic signed [T_W:0]      diff;
  logic signed [MIX_W-1:0]  mix_next;
  logic signed [MIX_W-1:0]  y;
  logic signed [ACT_W-1:0]  activation_next;

  assign acc_sum  = (ACC_W + 1)'(acc) + (ACC_W + 1)'(prod);
  assign acc_ovf  = acc_sum[ACC_W] ^ acc_sum[ACC_W-1];
  assign acc_sat  = acc_ovf ? {acc_sum[ACC_W], {(ACC_W - 1){~acc_sum[ACC_W]}}}
                            : acc_sum[ACC_W-1:0];

  assign bias_sum = (ACC_W + 1)'(acc) + ((ACC_W + 1)'(bias) <<< FRAC_BITS);
  assign bias_ovf = bias_sum[ACC_W] ^ bias_sum[ACC_W-1];
  assign bias_sat = bias_ovf ? {bias_sum[ACC_W], {(ACC_W - 1){~bias_sum[ACC_W]}}}
                             : bias_sum[ACC_W-1:0];

  assign rnd_sum  = (ACC_W + 1)'(total) + RND_HALF;

  assign u        = (X_W + 1)'(x) + HALF_SPAN;
  assign u_low    = u[X_W];
  assign u_high   = !u[X_W] && (|u[X_W-1:U_W]);
  assign scaled   = S_W'(u[U_W-1:0]) * SCALE;

  always_comb begin
    if (u_low) begin
      idx_next    = '0;
      idx_hi_next = '0;
      rem_next    = '0;
    end else if (u_high) begin
      idx_next    = LAST_IDX;
      idx_hi_next = LAST_IDX;
      rem_next    = '0;
    end else begin
      idx_next    = scaled[S_W-1:U_W];
      idx_hi_next = scaled[S_W-1:U_W] + IDX_W'(1);
      rem_next    = scaled[U_W-1:0];
    end
  end

  assign rom_addr = cmd.rd_hi ? idx_hi : idx;
  assign diff     = (T_W + 1)'(rom_data) - (T_W + 1)'(t_lo);
  assign mix_next = MIX_W'(diff) * MIX_W'($signed({1'b0, rem}));
  assign y        = MIX_W'(t_lo) + ((mix + MIX_HALF) >>> U_W);

  always_comb begin
    if (y > ACT_MAX) begin
      activation_next = ACT_MAX[ACT_W-1:0];
    end else if (y < ACT_MIN) begin
      activation_next = ACT_MIN[ACT_W-1:0];
    end else begin
      activation_next = y[ACT_W-1:0];
    end
  end

  nmac_act_rom #(
    .FRAC_BITS      (FRAC_BITS),
    .ACT_TABLE_SIZE (ACT_TABLE_SIZE)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bias      <= '0;
      acc       <= '0;
      clip_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        bias <= cfg_wdata;
      end
      if (cmd.acc) begin
        acc       <= acc_sat;
        clip_seen <= clip_seen | acc_ovf;
      end else if (cmd.add_bias) begin
        acc       <= '0;
        clip_seen <= 1'b0;
      end
      out_valid <= cmd.out_load | (out_valid & ~out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      in_mode   <= mode;
      in_value  <= value;
      in_weight <= weight;
      in_last   <= last;
    end
    if (cmd.mul) begin
      prod <= in_value * in_weight;
    end
    if (cmd.ld_direct) begin
      x        <= X_W'(in_value);
      res_clip <= 1'b0;
    end
    if (cmd.add_bias) begin
      total    <= bias_sat;
      res_clip <= bias_ovf | clip_seen;
    end
    if (cmd.round) begin
      x <= rnd_sum[ACC_W:FRAC_BITS];
    end
    if (cmd.map) begin
      idx      <= idx_next;
      idx_hi   <= idx_hi_next;
      rem      <= rem_next;
      res_clip <= res_clip | u_low | u_high;
    end
    if (cmd.cap_lo) begin
      t_lo <= rom_data;
    end
    if (cmd.mix) begin
      mix <= mix_next;
    end
    if (cmd.out_load) begin
      activation <= activation_next;
      saturated  <= res_clip;
    end
  end

  assign sts.mode     = in_mode;
  assign sts.last     = in_last;
  assign sts.out_busy = out_valid & ~out_ready;

endmodule

// ----- rtl/nmac_ctrl.sv -----
// ----------------------------------------------------------------------------
// nmac_ctrl
// Sequencer: multiply and accumulate per term; the last term goes on through
// bias, rounding, table lookup and interpolation; direct input skips to lookup.
// ----------------------------------------------------------------------------
module nmac_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  nmac_pkg::nmac_sts_t sts,
  output nmac_pkg::nmac_cmd_t cmd
);
  import nmac_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_MUL  = 10'b00_0000_0010,
    S_ACC  = 10'b00_0000_0100,
    S_BIAS = 10'b00_0000_1000,
    S_RND  = 10'b00_0001_0000,
    S_MAP  = 10'b00_0010_0000,
    S_RD0  = 10'b00_0100_0000,
    S_RD1  = 10'b00_1000_0000,
    S_MIX  = 10'b01_0000_0000,
    S_FIN  = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in  = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (sts.mode) begin
          cmd.ld_direct = 1'b1;
          state_next    = S_MAP;
        end else begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = sts.last ? S_BIAS : S_IDLE;
      end
      S_BIAS: begin
        cmd.add_bias = 1'b1;
        state_next   = S_RND;
      end
      S_RND: begin
        cmd.round  = 1'b1;
        state_next = S_MAP;
      end
      S_MAP: begin
        cmd.map    = 1'b1;
        state_next = S_RD0;
      end
      S_RD0: begin
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd_hi  = 1'b1;
        cmd.cap_lo = 1'b1;
        state_next = S_MIX;
      end
      S_MIX: begin
        cmd.mix    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

// ----- rtl/neuron_mac_with_activation.sv -----
// ----------------------------------------------------------------------------
// neuron_mac_with_activation: accepts a request only when idle, so a new term
// waits until the last is accumulated or its result is loaded into the output
// register. Both interpolation samples are read through one table read port.
// Reset clears accumulator, clip flag, bias and any pending result.
// ----------------------------------------------------------------------------
module neuron_mac_with_activation #(
  parameter int FRAC_BITS      = nmac_pkg::FRAC_BITS_DEF,
  parameter int ACT_TABLE_SIZE = nmac_pkg::ACT_TABLE_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic signed [nmac_pkg::DATA_W-1:0]  cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic signed [nmac_pkg::DATA_W-1:0]  value,
  input  logic signed [nmac_pkg::DATA_W-1:0]  weight,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [nmac_pkg::ACT_W-1:0]   activation,
  output logic                                saturated
);
  import nmac_pkg::*;

  nmac_cmd_t cmd;
  nmac_sts_t sts;

  nmac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nmac_dp #(
    .FRAC_BITS      (FRAC_BITS),
    .ACT_TABLE_SIZE (ACT_TABLE_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mode       (mode),
    .value      (value),
    .weight     (weight),
    .last       (last),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .activation (activation),
    .saturated  (saturated)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("result loaded over a pending result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one in flight");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result valid without a load");
`endif

endmodule
